### rtl/core/array_linked_list_engine_assert.svh
// Assertion macros used by the checker of the linked list engine.
`ifndef ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, reset masked.
`define ALLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masked.
`define ALLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/alle_pkg.sv
// Shared types, codes and constants of the linked list engine.
package alle_pkg;

  localparam int unsigned SlotsDefault = 16;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned CountW   = 5;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SIZE   = 2'd3
  } cmd_e;

  localparam logic [StatusW-1:0] STATUS_DONE = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL = 2'd1;
  localparam logic [StatusW-1:0] STATUS_MISS = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_WR,
    ST_WALK_HEAD,
    ST_WALK,
    ST_DEL_LINK,
    ST_DEL_FREE,
    ST_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic clr_wr;
    logic rd_free;
    logic ins_commit;
    logic walk_start;
    logic walk_step;
    logic save_succ;
    logic del_link;
    logic del_free;
    logic res_full;
    logic res_ins;
    logic res_empty;
    logic res_end;
    logic res_hit;
    logic load_out;
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e in_cmd;
    cmd_e cmd;
    logic init_last;
    logic free_good;
    logic head_good;
    logic hit;
    logic walk_last;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/core/alle_dp.sv
// Datapath: link and value memories, list pointers, walk registers, result register.
module alle_dp import alle_pkg::*; #(
  parameter int unsigned Slots = SlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_ctrl_t            ctrl_i,
  output dp_stat_t            stat_o,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                m_tready_i,
  output logic                m_tvalid_o,
  output logic [OutDataW-1:0] m_tdata_o
);

  localparam int unsigned IdxW  = $clog2(Slots);
  localparam int unsigned LinkW = IdxW + 1;
  localparam int unsigned CntW  = $clog2(Slots + 1);

  typedef logic signed [LinkW-1:0] link_t;

  localparam link_t           Nil      = '1;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(Slots - 1);
  localparam logic [CntW-1:0] SlotsCnt = CntW'(Slots);

  function automatic logic good(link_t s);
    return !s[LinkW-1] && (s[IdxW-1:0] <= LastIdx);
  endfunction

  // memories
  link_t             next_mem [Slots];
  logic [ValueW-1:0] val_mem  [Slots];

  link_t                    head_q, free_q, cur_q, prev_q, succ_q;
  link_t                    next_rd_q;
  logic [ValueW-1:0]        val_rd_q;
  logic signed [ValueW-1:0] value_q;
  cmd_e                     cmd_q;
  logic [IdxW-1:0]          init_q;
  logic [CntW-1:0]          steps_q;
  logic [CntW-1:0]          steps_inc;
  logic [StatusW-1:0]       res_status_q, miss_status;
  logic [SlotW-1:0]         res_slot_q;
  logic [CountW-1:0]        res_count_q;
  logic                     out_valid_q;
  logic [OutDataW-1:0]      out_data_q;

  logic                     wr_en;
  logic [IdxW-1:0]          wr_addr;
  link_t                    wr_data;
  logic [IdxW-1:0]          rd_addr;

  assign steps_inc   = steps_q + CntW'(1);
  assign miss_status = (cmd_q == CMD_SIZE) ? STATUS_DONE : STATUS_MISS;

  // link write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = init_q;
    wr_data = Nil;
    if (ctrl_i.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = init_q;
      wr_data = (init_q == LastIdx) ? Nil : link_t'({1'b0, init_q} + LinkW'(1));
    end else if (ctrl_i.ins_commit) begin
      wr_en   = 1'b1;
      wr_addr = free_q[IdxW-1:0];
      wr_data = head_q;
    end else if (ctrl_i.del_link && good(prev_q)) begin
      wr_en   = 1'b1;
      wr_addr = prev_q[IdxW-1:0];
      wr_data = succ_q;
    end else if (ctrl_i.del_free) begin
      wr_en   = 1'b1;
      wr_addr = cur_q[IdxW-1:0];
      wr_data = free_q;
    end
  end

  // read address
  always_comb begin
    rd_addr = cur_q[IdxW-1:0];
    if (ctrl_i.rd_free) begin
      rd_addr = free_q[IdxW-1:0];
    end else if (ctrl_i.walk_start) begin
      rd_addr = head_q[IdxW-1:0];
    end else if (ctrl_i.walk_step) begin
      rd_addr = next_rd_q[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      next_mem[wr_addr] <= wr_data;
    end
    if (ctrl_i.ins_commit) begin
      val_mem[free_q[IdxW-1:0]] <= value_q;
    end
    next_rd_q <= next_mem[rd_addr];
    val_rd_q  <= val_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= Nil;
      free_q      <= '0;
      init_q      <= '0;
      cmd_q       <= CMD_INSERT;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.clr_wr) begin
        init_q <= init_q + IdxW'(1);
      end
      if (ctrl_i.latch_in) begin
        cmd_q <= cmd_e'(s_tdata_i[1:0]);
      end
      if (ctrl_i.ins_commit) begin
        head_q <= free_q;
        free_q <= next_rd_q;
      end
      if (ctrl_i.del_link && !good(prev_q)) begin
        head_q <= succ_q;
      end
      if (ctrl_i.del_free) begin
        free_q <= cur_q;
      end
      if (ctrl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      value_q <= signed'(s_tdata_i[ValueW+1:2]);
    end
    if (ctrl_i.walk_start) begin
      cur_q   <= head_q;
      prev_q  <= Nil;
      steps_q <= '0;
    end
    if (ctrl_i.walk_step) begin
      prev_q  <= cur_q;
      cur_q   <= next_rd_q;
      steps_q <= steps_inc;
    end
    if (ctrl_i.save_succ) begin
      succ_q <= next_rd_q;
    end
    if (ctrl_i.res_full) begin
      res_status_q <= STATUS_FULL;
      res_slot_q   <= SlotW'(Nil);
      res_count_q  <= '0;
    end
    if (ctrl_i.res_ins) begin
      res_status_q <= STATUS_DONE;
      res_slot_q   <= SlotW'(free_q);
      res_count_q  <= '0;
    end
    if (ctrl_i.res_empty) begin
      res_status_q <= miss_status;
      res_slot_q   <= SlotW'(Nil);
      res_count_q  <= '0;
    end
    if (ctrl_i.res_end) begin
      res_status_q <= miss_status;
      res_slot_q   <= SlotW'(Nil);
      res_count_q  <= (cmd_q == CMD_SIZE) ? CountW'(steps_inc) : '0;
    end
    if (ctrl_i.res_hit) begin
      res_status_q <= STATUS_DONE;
      res_slot_q   <= SlotW'(cur_q);
      res_count_q  <= '0;
    end
    if (ctrl_i.load_out) begin
      out_data_q <= {(OutDataW - StatusW - SlotW - CountW)'(0),
                     res_count_q, res_slot_q, res_status_q};
    end
  end

  assign stat_o.in_cmd    = cmd_e'(s_tdata_i[1:0]);
  assign stat_o.cmd       = cmd_q;
  assign stat_o.init_last = (init_q == LastIdx);
  assign stat_o.free_good = good(free_q);
  assign stat_o.head_good = good(head_q);
  assign stat_o.hit       = (val_rd_q == value_q) && (cmd_q != CMD_SIZE);
  assign stat_o.walk_last = !good(next_rd_q) || (steps_inc == SlotsCnt);
  assign stat_o.out_free  = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

### rtl/core/alle_ctrl.sv
// Controller: sequences clearing, insert, list walks and unlinking.
module alle_ctrl import alle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  input  dp_stat_t stat_i,
  output dp_ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        ctrl_o.clr_wr = 1'b1;
        if (stat_i.init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          ctrl_o.latch_in = 1'b1;
          state_d = (stat_i.in_cmd == CMD_INSERT) ? ST_INS_CHK : ST_WALK_HEAD;
        end
      end
      ST_INS_CHK: begin
        if (stat_i.free_good) begin
          ctrl_o.rd_free = 1'b1;
          state_d = ST_INS_WR;
        end else begin
          ctrl_o.res_full = 1'b1;
          state_d = ST_RESP;
        end
      end
      ST_INS_WR: begin
        ctrl_o.ins_commit = 1'b1;
        ctrl_o.res_ins    = 1'b1;
        state_d = ST_RESP;
      end
      ST_WALK_HEAD: begin
        if (stat_i.head_good) begin
          ctrl_o.walk_start = 1'b1;
          state_d = ST_WALK;
        end else begin
          ctrl_o.res_empty = 1'b1;
          state_d = ST_RESP;
        end
      end
      ST_WALK: begin
        if (stat_i.hit) begin
          if (stat_i.cmd == CMD_DELETE) begin
            ctrl_o.save_succ = 1'b1;
            state_d = ST_DEL_LINK;
          end else begin
            ctrl_o.res_hit = 1'b1;
            state_d = ST_RESP;
          end
        end else if (stat_i.walk_last) begin
          ctrl_o.res_end = 1'b1;
          state_d = ST_RESP;
        end else begin
          ctrl_o.walk_step = 1'b1;
        end
      end
      ST_DEL_LINK: begin
        ctrl_o.del_link = 1'b1;
        state_d = ST_DEL_FREE;
      end
      ST_DEL_FREE: begin
        ctrl_o.del_free = 1'b1;
        ctrl_o.res_hit  = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/array_linked_list_engine.sv
// Top level of the array-based linked list engine with free list.
// A pool of Slots entries holds a singly threaded list of signed 32-bit values
// (newest first) and a free list, both chained through one next-link memory;
// values sit in a second memory. One request is taken at a time, one response
// comes back per request. Insert (command 0) pops a free slot and links the
// value at the head, or returns a full status when no slot is free. Search (1)
// and size (3) walk from the head, one next-link/value read per visited slot.
// Delete (2) walks like search, then unlinks the slot (the predecessor is
// remembered during the walk) and pushes it onto the free list. The response
// sits in an output register, so the next request is taken while the previous
// response still waits. After reset a clearing pass chains every slot into the
// free list; no request is taken during it.
module array_linked_list_engine import alle_pkg::*; #(
  parameter int unsigned Slots = SlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request: [1:0] command, [33:2] value, [39:34] zero
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // response: [1:0] status, [6:2] slot, [11:7] count, [15:12] zero
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  alle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  alle_dp #(
    .Slots (Slots)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .s_tdata_i  (s_axis_tdata_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule

### rtl/core/alle_chk.sv
// Port-level checker of the linked list engine and its bind.
`include "array_linked_list_engine_assert.svh"

module alle_chk import alle_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [StatusW-1:0] rsp_status;
  logic [SlotW-1:0]   rsp_slot;
  logic [CountW-1:0]  rsp_count;

  assign rsp_status = m_axis_tdata_o[1:0];
  assign rsp_slot   = m_axis_tdata_o[6:2];
  assign rsp_count  = m_axis_tdata_o[11:7];

  `ALLE_ASSERT_NXT(a_rsp_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o), "response dropped or changed while stalled")

  `ALLE_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid_i && s_axis_tready_o,
    !s_axis_tready_o, "request taken while another is in work")

  `ALLE_ASSERT_IMP(a_status_code, m_axis_tvalid_o,
    rsp_status == STATUS_DONE || rsp_status == STATUS_FULL || rsp_status == STATUS_MISS,
    "undefined status code")

  `ALLE_ASSERT_IMP(a_fail_no_slot, m_axis_tvalid_o && rsp_status != STATUS_DONE,
    rsp_slot == '1 && rsp_count == '0, "failed request reports a slot or count")

  `ALLE_ASSERT_IMP(a_count_only_size, m_axis_tvalid_o && rsp_count != '0,
    rsp_status == STATUS_DONE && rsp_slot == '1, "count on a response that is not a size")

endmodule

bind array_linked_list_engine alle_chk u_alle_chk (.*);
